### rtl/brld_pkg.sv
// Shared types and constants for the byte run-length decoder.
`timescale 1ns / 1ps

package brld_pkg;

    localparam int BYTE_W    = 8;
    localparam int COUNT_W   = 16;
    localparam int LIMIT_W   = 24;
    localparam int TOTAL_W   = 24;
    localparam int LIT_W     = 7;

    // header byte that announces a 16-bit little-endian run count (-122)
    localparam logic [BYTE_W-1:0] LONG_RUN_CODE = 8'h86;
    localparam logic [BYTE_W-1:0] END_CODE      = 8'h00;

    typedef enum logic [2:0] {
        PH_DONE,
        PH_HEADER,
        PH_LITERAL,
        PH_CNT_LO,
        PH_CNT_HI,
        PH_RUNBYTE
    } t_phase;

    typedef enum logic [1:0] {
        CAUSE_NONE  = 2'd0,
        CAUSE_END   = 2'd1,
        CAUSE_LIMIT = 2'd2
    } t_cause;

    typedef struct packed {
        logic [BYTE_W-1:0]  out_byte;
        logic [COUNT_W-1:0] repeat_count;
        logic               last;
        t_cause             end_cause;
        logic [TOTAL_W-1:0] total_out;
    } t_result;

endpackage

### rtl/brld_core.sv
// Decoder state and the per-byte state update that forms one result.
`timescale 1ns / 1ps

module brld_core #(
    parameter int LIMIT_BITS = 24
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_step,
    input  logic [brld_pkg::BYTE_W-1:0]     i_code_byte,
    input  logic                            i_first,
    input  logic [brld_pkg::LIMIT_W-1:0]    i_out_limit,
    output logic                            o_res_valid,
    output brld_pkg::t_result               o_res
);
    import brld_pkg::*;

    localparam int LW = LIMIT_BITS;

    t_phase              r_phase,    n_phase;
    logic [LW-1:0]       r_budget,   n_budget;
    logic [LIT_W-1:0]    r_lit_left, n_lit_left;
    logic [BYTE_W-1:0]   r_cnt_lo,   n_cnt_lo;
    logic [COUNT_W-1:0]  r_run_len,  n_run_len;
    logic [LW-1:0]       r_produced, n_produced;

    // width adapters between the fixed field widths and LIMIT_BITS
    logic [LW+LIMIT_W-1:0] limit_ext;
    logic [LW+BYTE_W-1:0]  byte_ext;
    logic [LW+COUNT_W-1:0] run_ext;
    logic [LW+TOTAL_W-1:0] total_ext;

    logic [LW-1:0]      limit_ld;
    logic [LW-1:0]      hdr_n;
    logic [LW-1:0]      run_n;
    logic [LW-1:0]      run_left;
    logic [LW-1:0]      prod_inc;
    logic [LIT_W-1:0]   lit_dec;
    t_phase             ph;
    logic [LW-1:0]      bud;
    logic [LW-1:0]      prod;

    assign limit_ext = {{LW{1'b0}}, i_out_limit};
    assign limit_ld  = limit_ext[LW-1:0];
    assign byte_ext  = {{LW{1'b0}}, i_code_byte};

    assign ph   = i_first ? PH_HEADER : r_phase;
    assign bud  = i_first ? limit_ld  : r_budget;
    assign prod = i_first ? '0        : r_produced;

    // literal count is clamped to the remaining budget
    assign hdr_n    = (byte_ext[LW-1:0] > bud) ? bud : byte_ext[LW-1:0];
    assign run_ext  = {{LW{1'b0}}, (i_first ? '0 : r_run_len)};
    assign run_n    = (run_ext[LW-1:0] > bud) ? bud : run_ext[LW-1:0];
    assign run_left = bud - run_n;
    assign prod_inc = prod + LW'(1);
    assign lit_dec  = (r_lit_left != '0) ? r_lit_left - LIT_W'(1) : '0;

    always_comb begin
        n_phase    = r_phase;
        n_budget   = r_budget;
        n_lit_left = r_lit_left;
        n_cnt_lo   = r_cnt_lo;
        n_run_len  = r_run_len;
        n_produced = r_produced;
        o_res_valid = 1'b0;
        o_res       = '0;
        total_ext   = {{TOTAL_W{1'b0}}, prod};

        if (i_first) begin
            n_budget   = limit_ld;
            n_produced = '0;
            n_lit_left = '0;
            n_cnt_lo   = '0;
            n_run_len  = '0;
        end

        if (i_first && limit_ld == '0) begin
            n_phase            = PH_DONE;
            o_res_valid        = 1'b1;
            o_res.last         = 1'b1;
            o_res.end_cause    = CAUSE_LIMIT;
        end else begin
            unique case (ph)
                PH_HEADER: begin
                    if (i_code_byte == END_CODE) begin
                        n_phase         = PH_DONE;
                        o_res_valid     = 1'b1;
                        o_res.last      = 1'b1;
                        o_res.end_cause = CAUSE_END;
                        o_res.total_out = total_ext[TOTAL_W-1:0];
                    end else if (!i_code_byte[BYTE_W-1]) begin
                        n_budget   = bud - hdr_n;
                        n_lit_left = hdr_n[LIT_W-1:0];
                        n_phase    = PH_LITERAL;
                    end else if (i_code_byte == LONG_RUN_CODE) begin
                        n_phase = PH_CNT_LO;
                    end else begin
                        // negate the signed header to get the run length
                        n_run_len = {{(COUNT_W-BYTE_W){1'b0}}, BYTE_W'(~i_code_byte + 8'd1)};
                        n_phase   = PH_RUNBYTE;
                    end
                end
                PH_LITERAL: begin
                    n_produced         = prod_inc;
                    n_lit_left         = lit_dec;
                    total_ext          = {{TOTAL_W{1'b0}}, prod_inc};
                    o_res_valid        = 1'b1;
                    o_res.out_byte     = i_code_byte;
                    o_res.repeat_count = COUNT_W'(1);
                    o_res.total_out    = total_ext[TOTAL_W-1:0];
                    if (lit_dec == '0) begin
                        if (bud == '0) begin
                            n_phase         = PH_DONE;
                            o_res.last      = 1'b1;
                            o_res.end_cause = CAUSE_LIMIT;
                        end else begin
                            n_phase = PH_HEADER;
                        end
                    end
                end
                PH_CNT_LO: begin
                    n_cnt_lo = i_code_byte;
                    n_phase  = PH_CNT_HI;
                end
                PH_CNT_HI: begin
                    n_run_len = {i_code_byte, r_cnt_lo};
                    n_phase   = PH_RUNBYTE;
                end
                PH_RUNBYTE: begin
                    n_budget  = run_left;
                    n_run_len = run_n[COUNT_W-1:0];
                    n_phase   = PH_HEADER;
                    // a zero-length long run consumes its byte silently
                    if (run_n != '0) begin
                        n_produced         = prod + run_n;
                        total_ext          = {{TOTAL_W{1'b0}}, prod + run_n};
                        o_res_valid        = 1'b1;
                        o_res.out_byte     = i_code_byte;
                        o_res.repeat_count = run_n[COUNT_W-1:0];
                        o_res.total_out    = total_ext[TOTAL_W-1:0];
                        if (run_left == '0) begin
                            n_phase         = PH_DONE;
                            o_res.last      = 1'b1;
                            o_res.end_cause = CAUSE_LIMIT;
                        end
                    end
                end
                PH_DONE: begin
                    // drop bytes until the next record starts
                end
                default: begin
                    n_phase = PH_DONE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_DONE;
            r_budget   <= '0;
            r_lit_left <= '0;
            r_cnt_lo   <= '0;
            r_run_len  <= '0;
            r_produced <= '0;
        end else if (i_step) begin
            r_phase    <= n_phase;
            r_budget   <= n_budget;
            r_lit_left <= n_lit_left;
            r_cnt_lo   <= n_cnt_lo;
            r_run_len  <= n_run_len;
            r_produced <= n_produced;
        end
    end

endmodule

### rtl/byte_run_length_decoder_unit.sv
// Top level of the byte run-length decoder: input register, decode step, result register.
// Throughput: one code byte per cycle while the result side takes each result.
// A byte goes through one decode step between the input and result registers.
// Synchronous active-low reset empties both registers and leaves the decoder
// done, waiting for the first byte of a record.
`timescale 1ns / 1ps

module byte_run_length_decoder_unit #(
    parameter int LIMIT_BITS = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // code_byte[7:0], out_limit[31:8]
    input  logic        i_s_axis_tuser,   // first
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata,   // out_byte[7:0], repeat_count[23:8], total_out[47:24]
    output logic        o_m_axis_tlast,   // last
    output logic [1:0]  o_m_axis_tuser    // end_cause
);
    import brld_pkg::*;

    logic                r_in_valid;
    logic [BYTE_W-1:0]   r_in_code;
    logic                r_in_first;
    logic [LIMIT_W-1:0]  r_in_limit;
    logic                r_out_valid;
    t_result             r_out;

    logic    step;
    logic    res_valid;
    t_result res;

    // advance the decode step when the result register is free or draining
    assign step            = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_code  <= i_s_axis_tdata[BYTE_W-1:0];
            r_in_limit <= i_s_axis_tdata[BYTE_W+LIMIT_W-1:BYTE_W];
            r_in_first <= i_s_axis_tuser;
        end
    end

    brld_core #(
        .LIMIT_BITS (LIMIT_BITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_code_byte (r_in_code),
        .i_first     (r_in_first),
        .i_out_limit (r_in_limit),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= res_valid;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && res_valid) begin
            r_out <= res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out.total_out, r_out.repeat_count, r_out.out_byte};
    assign o_m_axis_tlast  = r_out.last;
    assign o_m_axis_tuser  = r_out.end_cause;

endmodule

### rtl/brld_checker.sv
// Port-level checks for the byte run-length decoder and their bind.
`timescale 1ns / 1ps

module brld_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic [31:0] i_s_axis_tdata,
    input logic        i_s_axis_tuser,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [47:0] o_m_axis_tdata,
    input logic        o_m_axis_tlast,
    input logic [1:0]  o_m_axis_tuser
);
    import brld_pkg::*;

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled result changed");

    // the final result of a record, and only it, carries an end cause
    a_last_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tlast == (o_m_axis_tuser != CAUSE_NONE)))
        else $error("tlast does not match end cause");

    // the end code yields an empty result
    a_end_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser == CAUSE_END |-> o_m_axis_tdata[23:0] == 24'd0)
        else $error("end-code result carries data");

    // a running result always writes at least one byte
    a_run_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser == CAUSE_NONE |-> o_m_axis_tdata[23:8] != 16'd0)
        else $error("running result with zero count");

    // reset empties the result side
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind byte_run_length_decoder_unit brld_checker u_brld_checker (.*);
